[rtl/cfa_pkg.sv]
package cfa_pkg;

	localparam int FN_W       = 20;
	localparam int CNT_W      = 11;
	localparam int STAT_W     = 3;
	localparam int KIND_W     = 2;
	localparam int FPW        = 4;
	localparam int LANE_W     = 2;
	localparam int WORD_W     = 2 * FPW;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 40;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [WORD_W-1:0] WORD_ALL_FREE = 8'hFF;

	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_BODY  = 2'b00,
		ST_INACC = 2'b01,
		ST_HEAD  = 2'b10,
		ST_FREE  = 2'b11
	} frame_st_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_RANGE = 3'd1,
		STAT_NO_SPACE  = 3'd2,
		STAT_NOT_HEAD  = 3'd3,
		STAT_NOT_FREE  = 3'd4
	} status_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_MARK    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		M_SCAN,
		M_CHECK,
		M_FILL,
		M_FREE
	} sweep_mode_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DEC,
		S_SWEEP,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		sweep_mode_t      mode;
		logic [1:0]       head;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] run;
	} wu_ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  run;
		logic              hit;
		logic              not_head;
		logic [LANE_W-1:0] lane;
		logic [2:0]        freed;
	} wu_res_t;

endpackage

[rtl/contiguous_frame_allocator.sv]
// Page frame allocator with a 2-bit state per frame, kept four frames to a word in one RAM.
// Each request is handled alone by a sequencer that sweeps the RAM one word per cycle through a
// shared word unit, so the block is not ready until the result has been handed to the output
// register. An allocate request scans from frame zero until it finds the run and then writes the
// run. A mark request checks its range and then writes it, and a release walks
// from the head to the end of its run. Each request also passes through acceptance, decode and
// handoff, with a registered RAM read in every pass, and it waits in handoff while the previous
// result is still held in the output register. After reset and after every register write
// the RAM is cleared word by word to all free, during which no item is taken.
module contiguous_frame_allocator #(
	parameter int MAX_FRAMES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// frame_number [19:0], frame_count [30:20], zero fill [31]
	input  logic [cfa_pkg::S_TDATA_W-1:0]    s_tdata,
	// kind [1:0]
	input  logic [cfa_pkg::KIND_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// result_frame [19:0], status [22:20], free_frames [33:23], zero fill [39:34]
	output logic [cfa_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cfa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [cfa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [cfa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	import cfa_pkg::*;

	localparam int IW    = $clog2(MAX_FRAMES);
	localparam int NW    = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
	localparam int WORDS = (MAX_FRAMES + FPW - 1) / FPW;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int WW    = NW - LANE_W;

	ctrl_state_t       state_q, state_d;
	logic [FN_W-1:0]   base_q;
	logic [CNT_W-1:0]  pfc_q;
	logic [KIND_W-1:0] kind_q;
	logic [FN_W-1:0]   fn_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  free_total_q, free_d;
	logic [FN_W-1:0]   res_q, res_d;
	status_t           stat_q, stat_d;
	logic [WW-1:0]     clr_q;

	sweep_mode_t       mode_q;
	logic [1:0]        head_q;
	logic [NW-1:0]     lo_q, hi_q;
	logic [WW-1:0]     rd_word_q, last_word_q, word_s1;
	logic              issuing_q, v_s1;
	logic [CNT_W-1:0]  run_q;

	logic              m_valid_q;
	logic [FN_W-1:0]   out_res_q;
	status_t           out_stat_q;
	logic [CNT_W-1:0]  out_free_q;

	logic              cfg_we;
	logic [NW-1:0]     n_active;
	logic              fn_ge;
	logic [FN_W-1:0]   off_full;
	logic [FN_W:0]     mark_end;

	logic              launch;
	sweep_mode_t       launch_mode;
	logic [NW-1:0]     launch_lo, launch_hi;
	logic [1:0]        launch_head;
	logic              out_load;

	wu_ctl_t           wu_ctl;
	wu_res_t           wu_res;
	logic [NW-1:0]     hit_idx, alloc_start;
	logic              term, done;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	assign cfg_we   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_COUNT) ? APB_DATA_W'(pfc_q) : APB_DATA_W'(base_q);

	assign n_active = (NW'(pfc_q) < NW'(MAX_FRAMES)) ? NW'(pfc_q) : NW'(MAX_FRAMES);
	assign fn_ge    = (fn_q >= base_q);
	assign off_full = fn_q - base_q;
	assign mark_end = {1'b0, off_full} + (FN_W + 1)'(cnt_q);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'({out_free_q, out_stat_q, out_res_q});

	assign wu_ctl.mode = mode_q;
	assign wu_ctl.head = head_q;
	assign wu_ctl.cnt  = cnt_q;
	assign wu_ctl.run  = run_q;

	cfa_word_unit #(
		.IDX_W(NW)
	) u_word_unit (
		.ctl      (wu_ctl),
		.word_base({word_s1, LANE_W'(0)}),
		.lo       (lo_q),
		.hi       (hi_q),
		.word_in  (ram_rdata),
		.res      (wu_res)
	);

	assign hit_idx     = {word_s1, wu_res.lane};
	assign alloc_start = hit_idx + 1'b1 - NW'(cnt_q);
	assign term        = ((mode_q == M_SCAN || mode_q == M_CHECK) && wu_res.hit) ||
	                     (mode_q == M_FREE && (wu_res.hit || wu_res.not_head));
	assign done        = (state_q == S_SWEEP) && v_s1 && ((word_s1 == last_word_q) || term);

	assign ram_we    = (state_q == S_CLEAR) ||
	                   ((state_q == S_SWEEP) && v_s1 && (mode_q == M_FILL || mode_q == M_FREE));
	assign ram_waddr = (state_q == S_CLEAR) ? AW'(clr_q) : AW'(word_s1);
	assign ram_wdata = (state_q == S_CLEAR) ? WORD_ALL_FREE : wu_res.word;
	assign ram_re    = (state_q == S_SWEEP) && issuing_q;
	assign ram_raddr = AW'(rd_word_q);

	cfa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d     = state_q;
		launch      = 1'b0;
		launch_mode = M_SCAN;
		launch_lo   = '0;
		launch_hi   = '0;
		launch_head = ST_HEAD;
		stat_d      = stat_q;
		res_d       = res_q;
		free_d      = free_total_q;
		out_load    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				free_d = CNT_W'(n_active);
				if (clr_q == WW'(WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				res_d   = '0;
				stat_d  = STAT_BAD_RANGE;
				state_d = S_OUT;
				case (kind_q)
					KIND_ALLOC: begin
						if (cnt_q == '0) begin
							stat_d = STAT_BAD_RANGE;
						end else if (NW'(cnt_q) > n_active) begin
							stat_d = STAT_NO_SPACE;
						end else begin
							launch      = 1'b1;
							launch_mode = M_SCAN;
							launch_lo   = '0;
							launch_hi   = n_active;
							state_d     = S_SWEEP;
						end
					end
					KIND_RELEASE: begin
						if (fn_ge && (off_full < FN_W'(n_active))) begin
							launch      = 1'b1;
							launch_mode = M_FREE;
							launch_lo   = NW'(off_full);
							launch_hi   = n_active;
							stat_d      = STAT_OK;
							state_d     = S_SWEEP;
						end
					end
					KIND_MARK: begin
						if ((cnt_q != '0) && fn_ge && (mark_end <= (FN_W + 1)'(n_active))) begin
							launch      = 1'b1;
							launch_mode = M_CHECK;
							launch_lo   = NW'(off_full);
							launch_hi   = NW'(off_full) + NW'(cnt_q);
							state_d     = S_SWEEP;
						end
					end
					default: begin
						stat_d = STAT_BAD_RANGE;
					end
				endcase
			end
			S_SWEEP: begin
				if (v_s1 && mode_q == M_FREE) begin
					free_d = free_total_q + CNT_W'(wu_res.freed);
				end
				if (done) begin
					case (mode_q)
						M_SCAN: begin
							if (wu_res.hit) begin
								launch      = 1'b1;
								launch_mode = M_FILL;
								launch_lo   = alloc_start;
								launch_hi   = hit_idx + 1'b1;
								launch_head = ST_HEAD;
								res_d       = base_q + FN_W'(alloc_start);
								stat_d      = STAT_OK;
								free_d      = free_total_q - cnt_q;
							end else begin
								stat_d  = STAT_NO_SPACE;
								state_d = S_OUT;
							end
						end
						M_CHECK: begin
							if (wu_res.hit) begin
								stat_d  = STAT_NOT_FREE;
								state_d = S_OUT;
							end else begin
								launch      = 1'b1;
								launch_mode = M_FILL;
								launch_lo   = lo_q;
								launch_hi   = hi_q;
								launch_head = ST_INACC;
								stat_d      = STAT_OK;
								free_d      = free_total_q - cnt_q;
							end
						end
						M_FILL: begin
							state_d = S_OUT;
						end
						M_FREE: begin
							if (wu_res.not_head) begin
								stat_d = STAT_NOT_HEAD;
							end
							state_d = S_OUT;
						end
						default: begin
							state_d = S_OUT;
						end
					endcase
				end
			end
			S_OUT: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		if (cfg_we) begin
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			base_q       <= '0;
			pfc_q        <= CNT_W'(1024);
			clr_q        <= '0;
			issuing_q    <= 1'b0;
			v_s1         <= 1'b0;
			m_valid_q    <= 1'b0;
			free_total_q <= '0;
		end else begin
			state_q      <= state_d;
			free_total_q <= free_d;
			if (cfg_we) begin
				if (paddr[2] == REG_COUNT) begin
					pfc_q <= pwdata[CNT_W-1:0];
				end else begin
					base_q <= pwdata[FN_W-1:0];
				end
			end
			if (cfg_we) begin
				clr_q <= '0;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (launch) begin
				issuing_q <= 1'b1;
				v_s1      <= 1'b0;
			end else if (state_q == S_SWEEP) begin
				if (done) begin
					issuing_q <= 1'b0;
					v_s1      <= 1'b0;
				end else begin
					v_s1 <= issuing_q;
					if (issuing_q && rd_word_q == last_word_q) begin
						issuing_q <= 1'b0;
					end
				end
			end else begin
				issuing_q <= 1'b0;
				v_s1      <= 1'b0;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= res_d;
		stat_q <= stat_d;
		if (state_q == S_IDLE && s_tvalid) begin
			kind_q <= s_tuser;
			fn_q   <= s_tdata[FN_W-1:0];
			cnt_q  <= s_tdata[FN_W +: CNT_W];
		end
		if (launch) begin
			mode_q      <= launch_mode;
			head_q      <= launch_head;
			lo_q        <= launch_lo;
			hi_q        <= launch_hi;
			rd_word_q   <= WW'(launch_lo >> LANE_W);
			last_word_q <= WW'((launch_hi - 1'b1) >> LANE_W);
			run_q       <= '0;
		end else if (state_q == S_SWEEP) begin
			word_s1 <= rd_word_q;
			if (issuing_q && rd_word_q != last_word_q) begin
				rd_word_q <= rd_word_q + 1'b1;
			end
			if (v_s1) begin
				run_q <= wu_res.run;
			end
		end
		if (out_load) begin
			out_res_q  <= res_q;
			out_stat_q <= stat_q;
			out_free_q <= free_total_q;
		end
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> (NW'(free_total_q) <= n_active))
		else $error("free count exceeds the frames in use");

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("state RAM read and write hit the same word");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_stat_q != STAT_OK) |-> (out_res_q == '0))
		else $error("failed request returns a nonzero frame");

	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !cfg_we) |=> (state_q == S_DEC))
		else $error("accepted item did not enter decode");

endmodule

[rtl/cfa_ram.sv]
module cfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/cfa_word_unit.sv]
module cfa_word_unit #(
	parameter int IDX_W = 11
) (
	input  cfa_pkg::wu_ctl_t               ctl,
	input  logic [IDX_W-1:0]               word_base,
	input  logic [IDX_W-1:0]               lo,
	input  logic [IDX_W-1:0]               hi,
	input  logic [cfa_pkg::WORD_W-1:0]     word_in,
	output cfa_pkg::wu_res_t               res
);

	import cfa_pkg::*;

	always_comb begin
		logic [IDX_W-1:0]  idx;
		logic              in_rng;
		logic              stop;
		logic [1:0]        code;
		logic [1:0]        code_new;
		logic [CNT_W-1:0]  run;
		logic [2:0]        freed;
		logic [WORD_W-1:0] w;
		logic              hit;
		logic              nh;
		logic [LANE_W-1:0] lane;
		w     = word_in;
		run   = ctl.run;
		stop  = 1'b0;
		hit   = 1'b0;
		nh    = 1'b0;
		freed = '0;
		lane  = '0;
		for (int j = 0; j < FPW; j++) begin
			idx      = word_base + IDX_W'(j);
			in_rng   = (idx >= lo) && (idx < hi);
			code     = word_in[2*j +: 2];
			code_new = code;
			if (in_rng && !stop) begin
				case (ctl.mode)
					M_SCAN: begin
						if (code == ST_FREE) begin
							run = run + 1'b1;
							if (run == ctl.cnt) begin
								hit  = 1'b1;
								stop = 1'b1;
								lane = LANE_W'(j);
							end
						end else begin
							run = '0;
						end
					end
					M_CHECK: begin
						if (code != ST_FREE) begin
							hit  = 1'b1;
							stop = 1'b1;
						end
					end
					M_FILL: begin
						code_new = (idx == lo) ? ctl.head : ST_BODY;
					end
					M_FREE: begin
						if (idx == lo) begin
							if (code == ST_HEAD) begin
								code_new = ST_FREE;
								freed    = freed + 3'd1;
							end else begin
								nh   = 1'b1;
								stop = 1'b1;
							end
						end else if (code == ST_BODY) begin
							code_new = ST_FREE;
							freed    = freed + 3'd1;
						end else begin
							hit  = 1'b1;
							stop = 1'b1;
						end
					end
					default: begin
						code_new = code;
					end
				endcase
			end
			w[2*j +: 2] = code_new;
		end
		res.word     = w;
		res.run      = run;
		res.hit      = hit;
		res.not_head = nh;
		res.lane     = lane;
		res.freed    = freed;
	end

endmodule
